// ===== rtl/core/tgr_pkg.sv =====
`default_nettype none

package tgr_pkg;

  localparam int GLYPH_ROWS = 16;
  // Power of two: font addresses wrap by dropping high bits.
  localparam int FONT_BYTES = 8192;
  localparam int CELL_W     = 8;

  localparam int FONT_AW   = $clog2(FONT_BYTES);
  localparam int ROW_CNT_W = $clog2(GLYPH_ROWS + 1);

  localparam int SW_W     = 14;
  localparam int STRIDE_W = 14;
  localparam int COLOR_W  = 32;
  localparam int GB_W     = 6;
  localparam int CODE_W   = 8;
  localparam int LADDR_W  = 13;
  localparam int BYTE_W   = 8;
  localparam int CUR_W    = 16;
  localparam int OFFS_W   = 32;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEN_COLOR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_BYTES  = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SETUP = 3'b010,
    S_ROWS  = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tgr_ram.sv =====
`default_nettype none

module tgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/text_glyph_renderer.sv =====
// Font load: each transaction writes one byte of the font RAM, no result.
// Draw: after acceptance a setup state forms the glyph base and pixel offset; rows then
// follow one per cycle while out is not stalled, read through the single font RAM read
// port and the offset adder. No new input is taken until the last row has moved.
// Reset (rst_n low, synchronous): cursor to 0,0, registers to their defaults, output empty.
// Font RAM contents are not cleared.
`default_nettype none

module text_glyph_renderer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // char_code[7:0], load_address[20:8], load_data[28:21], zero fill
  input  wire logic [tgr_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode[0]
  input  wire logic [tgr_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // pixel_offset[31:0], row_mask[39:32], row_color[71:40]
  output logic      [tgr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                    out_tlast,
  input  wire logic                               cfg_we,
  input  wire logic [tgr_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [tgr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import tgr_pkg::*;

  state_t state_r, state_nxt;

  logic [SW_W-1:0]      screen_width_r;
  logic [STRIDE_W-1:0]  line_stride_r;
  logic [COLOR_W-1:0]   pen_color_r;
  logic [GB_W-1:0]      glyph_bytes_r;
  logic [CUR_W-1:0]     cursor_x_r, cursor_x_nxt;
  logic [CUR_W-1:0]     cursor_y_r, cursor_y_nxt;

  logic [CODE_W-1:0]    code_r;
  logic [FONT_AW-1:0]   base_r;
  logic [OFFS_W-1:0]    offs_r;
  logic [ROW_CNT_W-1:0] iss_cnt_r;

  logic                 pend_r;
  logic [OFFS_W-1:0]    pend_offs_r;
  logic                 pend_last_r;

  logic                 out_vld_r;
  logic [OFFS_W-1:0]    out_offs_r;
  logic [BYTE_W-1:0]    out_mask_r;
  logic [COLOR_W-1:0]   out_color_r;
  logic                 out_last_r;

  logic                 in_acc;
  logic                 mode;
  logic [CODE_W-1:0]    in_code;
  logic [LADDR_W-1:0]   in_laddr;
  logic [BYTE_W-1:0]    in_ldata;

  logic                 move;
  logic                 issue;
  logic [FONT_AW-1:0]   rd_addr;
  logic [BYTE_W-1:0]    rd_data;

  logic [STRIDE_W+CUR_W-1:0] y_prod;
  logic [CODE_W+GB_W-1:0]    g_prod;
  logic [CUR_W:0]            x_step;
  logic [CUR_W:0]            x_edge;
  logic [CUR_W:0]            y_step;

  assign mode     = in_tuser[0];
  assign in_code  = in_tdata[CODE_W-1:0];
  assign in_laddr = in_tdata[CODE_W+LADDR_W-1:CODE_W];
  assign in_ldata = in_tdata[CODE_W+LADDR_W+BYTE_W-1:CODE_W+LADDR_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Row data moves from the RAM read register into the output register.
  assign move  = pend_r && (!out_vld_r || out_tready);
  assign issue = (state_r == S_ROWS) && (iss_cnt_r != ROW_CNT_W'(GLYPH_ROWS))
                 && (!pend_r || move);
  assign rd_addr = base_r + FONT_AW'(iss_cnt_r);

  tgr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FONT_BYTES)
  ) u_font (
    .clk   (clk),
    .we    (in_acc && (mode == MODE_LOAD)),
    .waddr (in_laddr[FONT_AW-1:0]),
    .wdata (in_ldata),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign y_prod = cursor_y_r * line_stride_r;
  assign g_prod = code_r * glyph_bytes_r;
  assign x_step = {1'b0, cursor_x_r} + (CUR_W+1)'(CELL_W);
  assign x_edge = {1'b0, x_step[CUR_W-1:0]} + (CUR_W+1)'(CELL_W);
  assign y_step = {1'b0, cursor_y_r} + (CUR_W+1)'(GLYPH_ROWS);

  always_comb begin
    cursor_x_nxt = x_step[CUR_W-1:0];
    cursor_y_nxt = cursor_y_r;
    if (x_edge > (CUR_W+1)'(screen_width_r)) begin
      cursor_x_nxt = '0;
      cursor_y_nxt = y_step[CUR_W] ? {CUR_W{1'b1}} : y_step[CUR_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (mode == MODE_DRAW)) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        state_nxt = S_ROWS;
      end
      S_ROWS: begin
        if (move && pend_last_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      screen_width_r <= SW_W'(1024);
      line_stride_r  <= STRIDE_W'(1024);
      pen_color_r    <= {COLOR_W{1'b1}};
      glyph_bytes_r  <= GB_W'(16);
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      iss_cnt_r      <= '0;
      pend_r         <= 1'b0;
      out_vld_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SCREEN_WIDTH: screen_width_r <= cfg_wdata[SW_W-1:0];
          REG_LINE_STRIDE:  line_stride_r  <= cfg_wdata[STRIDE_W-1:0];
          REG_PEN_COLOR:    pen_color_r    <= cfg_wdata[COLOR_W-1:0];
          REG_GLYPH_BYTES:  glyph_bytes_r  <= cfg_wdata[GB_W-1:0];
          default: ;
        endcase
      end

      // Setup samples the old cursor for the offset, then advance it.
      if (state_r == S_SETUP) begin
        cursor_x_r <= cursor_x_nxt;
        cursor_y_r <= cursor_y_nxt;
        iss_cnt_r  <= '0;
      end else if (issue) begin
        iss_cnt_r <= iss_cnt_r + ROW_CNT_W'(1);
      end

      if (issue) begin
        pend_r <= 1'b1;
      end else if (move) begin
        pend_r <= 1'b0;
      end

      if (move) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      code_r <= in_code;
    end
    if (state_r == S_SETUP) begin
      base_r <= g_prod[FONT_AW-1:0];
      offs_r <= OFFS_W'(y_prod) + OFFS_W'(cursor_x_r);
    end else if (issue) begin
      offs_r <= offs_r + OFFS_W'(line_stride_r);
    end
    if (issue) begin
      pend_offs_r <= offs_r;
      pend_last_r <= (iss_cnt_r == ROW_CNT_W'(GLYPH_ROWS - 1));
    end
    if (move) begin
      out_offs_r  <= pend_offs_r;
      out_mask_r  <= rd_data;
      out_color_r <= pen_color_r;
      out_last_r  <= pend_last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_color_r, out_mask_r, out_offs_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_setup_then_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETUP) |=> (state_r == S_ROWS) && (iss_cnt_r == '0))
    else $error("setup did not start a fresh row sequence");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss_cnt_r <= ROW_CNT_W'(GLYPH_ROWS))
    else $error("row issue count overran the glyph height");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (move && pend_last_r) |=> (state_r == S_IDLE) && out_tlast && out_tvalid)
    else $error("last row moved without ending the character");

  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ROWS) |-> !issue && !(pend_r && (state_r == S_SETUP)))
    else $error("font read outside the row phase");
`endif

endmodule

`default_nettype wire

// ===== dv/glyph_row_checker.sv =====
module glyph_row_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // char_code, load_address, load_data, zero fill
  input  logic [tgr_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic [tgr_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_offset, row_mask, row_color
  input  logic [tgr_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [tgr_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [tgr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             rows_pending,
  output int                             rows_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import tgr_pkg::*;

  localparam int CODE_LSB   = 0;
  localparam int LADDR_LSB  = CODE_W;
  localparam int LDATA_LSB  = CODE_W + LADDR_W;
  localparam int MASK_LSB   = OFFS_W;
  localparam int COLOR_LSB  = OFFS_W + BYTE_W;

  typedef struct packed {
    logic [OFFS_W-1:0]  offset;
    logic [BYTE_W-1:0]  mask;
    logic [COLOR_W-1:0] color;
    logic               last;
  } row_write_t;

  row_write_t         row_queue[$];
  logic [BYTE_W-1:0]  font_copy [FONT_BYTES];
  logic [SW_W-1:0]    width_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [COLOR_W-1:0] pen_q;
  logic [GB_W-1:0]    gb_q;
  logic [CUR_W-1:0]   cur_x;
  logic [CUR_W-1:0]   cur_y;

  initial begin
    fail_count   = 0;
    rows_pending = 0;
    rows_checked = 0;
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Queue the sixteen row writes of one character, then advance the cursor.
  task automatic predict_glyph(input logic [CODE_W-1:0] code);
    row_write_t       row;
    int unsigned      base;
    logic [63:0]      offs;
    logic [CUR_W:0]   next_y;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      base       = code * gb_q + r;
      offs       = (64'(cur_y) + r) * stride_q + cur_x;
      row.offset = offs[OFFS_W-1:0];
      row.mask   = font_copy[base % FONT_BYTES];
      row.color  = pen_q;
      row.last   = (r == GLYPH_ROWS - 1);
      row_queue.push_back(row);
    end
    cur_x = CUR_W'(cur_x + CELL_W);
    if (32'(cur_x) + CELL_W > width_q) begin
      next_y = (CUR_W+1)'(cur_y + GLYPH_ROWS);
      cur_x  = '0;
      // saturate at the top of the 16-bit range
      cur_y  = (next_y > 17'h0FFFF) ? '1 : next_y[CUR_W-1:0];
    end
  endtask

  always @(posedge clk) begin
    row_write_t want;
    if (!rst_n) begin
      width_q  = 14'd1024;
      stride_q = 14'd1024;
      pen_q    = 32'hFFFF_FFFF;
      gb_q     = 6'd16;
      cur_x    = '0;
      cur_y    = '0;
      row_queue.delete();
    end else begin
      // retire before predicting: a row can never leave in its own accept cycle
      if (out_tvalid && out_tready) begin
        if (row_queue.size() == 0) begin
          $display("%0t: unexpected row write: expected none, got %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = row_queue.pop_front();
          check_field("pixel_offset", want.offset, out_tdata[0 +: OFFS_W]);
          check_field("row_mask", 32'(want.mask), 32'(out_tdata[MASK_LSB +: BYTE_W]));
          check_field("row_color", want.color, out_tdata[COLOR_LSB +: COLOR_W]);
          check_field("last_row", 32'(want.last), 32'(out_tlast));
          rows_checked++;
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_SCREEN_WIDTH: width_q  = cfg_wdata[SW_W-1:0];
          REG_LINE_STRIDE:  stride_q = cfg_wdata[STRIDE_W-1:0];
          REG_PEN_COLOR:    pen_q    = cfg_wdata[COLOR_W-1:0];
          REG_GLYPH_BYTES:  gb_q     = cfg_wdata[GB_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == MODE_DRAW)
          predict_glyph(in_tdata[CODE_LSB +: CODE_W]);
        else
          font_copy[in_tdata[LADDR_LSB +: LADDR_W]] = in_tdata[LDATA_LSB +: BYTE_W];
      end
    end
    rows_pending = row_queue.size();
  end

endmodule

// ===== dv/tb_text_glyph_renderer.sv =====
module tb_text_glyph_renderer;
  timeunit 1ns;
  timeprecision 1ps;

  import tgr_pkg::*;

  localparam int TIMEOUT_CYCLES   = 1_000_000;
  localparam int DRAIN_CYCLES     = 24;
  localparam int RANDOM_SEGMENTS  = 9;
  localparam int SEGMENT_ITEMS    = 45;
  localparam int PRESSURE_SEGMENT = 6;
  localparam int LONG_HOLD        = 400;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // char_code[7:0], load_address[20:8], load_data[28:21], zero fill
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // mode[0]
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // pixel_offset[31:0], row_mask[39:32], row_color[71:40]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = REG_SCREEN_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int          fail_count;
  int          rows_pending;
  int          rows_checked;
  int          send_idle_pct   = 0;
  int          recv_idle_pct   = 0;
  bit          hold_req        = 1'b0;
  bit          hold_done       = 1'b0;
  int          hold_left       = 0;
  bit          font_written [FONT_BYTES];
  int unsigned glyph_bytes_cfg = 16;
  int          draws_sent      = 0;
  int          loads_sent      = 0;
  int          settings_used   = 0;

  text_glyph_renderer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  glyph_row_checker u_row_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .rows_pending (rows_pending),
    .rows_checked (rows_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Row sink: random back-pressure, plus one long hold so the block backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= LONG_HOLD;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic mode, input logic [CODE_W-1:0] code,
                           input logic [LADDR_W-1:0] laddr, input logic [BYTE_W-1:0] ldata);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {3'b000, ldata, laddr, code};
    // in_tready is settled by the falling edge; the transaction lands on the next rise
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    if (mode == MODE_DRAW)
      draws_sent++;
    else
      loads_sent++;
  endtask

  task automatic load_font_byte(input logic [LADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
    send_item(MODE_LOAD, CODE_W'($urandom), addr, data);
    font_written[addr] = 1'b1;
  endtask

  // Load any glyph row not yet in the store (or all of them on refresh), then draw.
  task automatic draw_char(input logic [CODE_W-1:0] code, input bit refresh);
    int unsigned a;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      a = (code * glyph_bytes_cfg + r) % FONT_BYTES;
      if (refresh || !font_written[a])
        load_font_byte(a[LADDR_W-1:0], BYTE_W'($urandom));
    end
    send_item(MODE_DRAW, code, LADDR_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (rows_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [SW_W-1:0] width, input logic [STRIDE_W-1:0] stride,
                               input logic [COLOR_W-1:0] pen, input logic [GB_W-1:0] gb);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SCREEN_WIDTH;
    cfg_wdata <= CFG_DATA_W'(width);
    @(posedge clk);
    cfg_addr  <= REG_LINE_STRIDE;
    cfg_wdata <= CFG_DATA_W'(stride);
    @(posedge clk);
    cfg_addr  <= REG_PEN_COLOR;
    cfg_wdata <= CFG_DATA_W'(pen);
    @(posedge clk);
    cfg_addr  <= REG_GLYPH_BYTES;
    cfg_wdata <= CFG_DATA_W'(gb);
    @(posedge clk);
    cfg_we <= 1'b0;
    glyph_bytes_cfg = gb;
    settings_used++;
  endtask

  // Mostly load-then-draw sequences over a small hot set of codes, some stray loads.
  task automatic run_segment(input int target);
    int               start_items;
    logic [CODE_W-1:0] code;
    start_items = draws_sent + loads_sent;
    while (draws_sent + loads_sent - start_items < target) begin
      if ($urandom_range(3) != 0) begin
        code = $urandom_range(1) ? CODE_W'($urandom_range(7)) : CODE_W'($urandom);
        draw_char(code, $urandom_range(4) == 0);
        repeat ($urandom_range(3)) draw_char(code, 1'b0);
      end else begin
        load_font_byte(LADDR_W'($urandom), BYTE_W'($urandom));
      end
    end
  endtask

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("text_glyph_renderer test failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Glyph for code zero with all-clear, all-set, leftmost-only and rightmost-only rows.
    for (int r = 0; r < GLYPH_ROWS; r++)
      load_font_byte(LADDR_W'(r), (r == 0) ? 8'h00 : (r == 1) ? 8'hFF :
                                  (r == 2) ? 8'h80 : (r == 3) ? 8'h01 : BYTE_W'($urandom));
    load_font_byte('1, 8'hA5);
    draw_char(8'd0, 1'b0);
    draw_char(8'd0, 1'b0);
    // zero glyph size: every code reads the same rows; narrow screen wraps each time
    apply_setting(14'd7, 14'd0, 32'h0, 6'd0);
    draw_char(8'd255, 1'b0);
    draw_char(8'd1, 1'b0);
    apply_setting('1, '1, '1, 6'd32);
    draw_char(8'd0, 1'b0);

    for (int s = 0; s < RANDOM_SEGMENTS; s++) begin
      case (s)
        0: apply_setting('1, '1, '1, '1);
        1: apply_setting(14'd8, 14'd8, '0, 6'd16);
        2: apply_setting(SW_W'($urandom_range(7)), '0, COLOR_W'($urandom), '0);
        default:
          apply_setting(SW_W'($urandom_range(8, 2048)), STRIDE_W'($urandom_range(8, 4096)),
                        COLOR_W'($urandom),
                        ($urandom_range(3) == 0) ? GB_W'($urandom) : GB_W'($urandom_range(16, 32)));
      endcase
      send_idle_pct = (s < 3) ? 20 : (s < 6) ? 49 : 0;
      recv_idle_pct = (s < 3) ? 49 : (s < 6) ? 20 : 0;
      if (s == PRESSURE_SEGMENT)
        hold_req = 1'b1;
      run_segment(SEGMENT_ITEMS);
    end
    wait_idle();

    $display("Ran %0d character draws and %0d font loads across %0d register settings,",
             draws_sent, loads_sent, settings_used);
    $display("checking %0d row writes, including narrow-screen wraps and zero glyph size.",
             rows_checked);
    if (fail_count == 0 && rows_pending == 0)
      $display("text_glyph_renderer test passed");
    else
      $display("text_glyph_renderer test failed");
    $finish;
  end

endmodule
